// ===== hw/rtl/lrs_pkg.sv =====
// Shared types, codes and constants of the learning-rate scheduler.
// Holds the controller/datapath command and status structs and the cosine table function.
// Depends on nothing.
package lrs_pkg;

   localparam int RATE_W     = 32;
   localparam int GAMMA_W    = 17;
   localparam int EPOCH_W    = 16;
   localparam int LOSS_W     = 32;
   localparam int H_W        = 31;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] MODE_STEP     = 2'd0;
   localparam logic [1:0] MODE_COSINE   = 2'd1;
   localparam logic [1:0] MODE_PLATEAU  = 2'd2;
   localparam logic [1:0] MODE_EXP      = 2'd3;

   localparam logic ACT_START     = 1'b0;
   localparam logic ACT_EPOCH_END = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATIENCE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL    = 3'd5;

   localparam logic [RATE_W-1:0]  RATE_MAX   = 32'hFFFF_FFFF;
   localparam logic [GAMMA_W-1:0] DECAY_ONE  = 17'd65536;
   localparam logic [63:0]        PI_Q30     = 64'd3373259426;
   localparam logic [63:0]        Q30_ONE    = 64'd1073741824;

   typedef enum logic [1:0] {
      DIV_STEP,
      DIV_PHASE,
      DIV_INDEX
   } div_sel_type;

   typedef enum logic [1:0] {
      MUL_SCALE,
      MUL_COS,
      MUL_RG,
      MUL_GG
   } mul_sel_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_CUR_SCALE,
      WB_CUR_COS,
      WB_R,
      WB_G,
      WB_CUR_R
   } wb_sel_type;

   typedef struct packed {
      logic        capture;
      logic        start_load;
      logic        div_start;
      div_sel_type div_sel;
      logic        phase_wb;
      logic        rom_rd;
      logic        mul_en;
      mul_sel_type mul_sel;
      wb_sel_type  wb_sel;
      logic        pow_init;
      logic        pow_shift;
      logic        plat_eval;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic       action;
      logic [1:0] mode;
      logic       div_busy;
      logic       rem_zero;
      logic       pow_bit;
      logic       plat_decay;
   } status_type;

   // cos(theta)^2 in Q1.30, theta in Q30; Taylor series in Horner form
   function automatic logic [H_W-1:0] cos_sq_q30(input logic [63:0] theta);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] p;
      logic [63:0] h;
      x2 = (theta * theta) >> 30;
      t  = Q30_ONE;
      p  = ((x2 * t) >> 30) / 64'd182;
      t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      p  = ((x2 * t) >> 30) / 64'd132;
      t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      p  = ((x2 * t) >> 30) / 64'd90;
      t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      p  = ((x2 * t) >> 30) / 64'd56;
      t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      p  = ((x2 * t) >> 30) / 64'd30;
      t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      p  = ((x2 * t) >> 30) / 64'd12;
      t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      p  = ((x2 * t) >> 30) / 64'd2;
      t  = (p >= Q30_ONE) ? 64'd0 : Q30_ONE - p;
      h  = (t * t) >> 30;
      if (h > Q30_ONE) begin
         h = Q30_ONE;
      end
      return h[H_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/lrs_divider.sv =====
// Restoring divider, one quotient bit per cycle, giving quotient and remainder.
// Standalone; used by the scheduler datapath.
module lrs_divider #(
   parameter int DIVIDEND_W = 24,
   parameter int DIVISOR_W  = 17
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quo_ff;
   logic [DIVISOR_W-1:0]  rem_ff;
   logic [DIVISOR_W-1:0]  dvs_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;

   logic [DIVISOR_W:0]    partial;
   logic                  fits;
   logic [DIVISOR_W:0]    diff;

   assign partial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign fits    = (partial >= {1'b0, dvs_ff});
   assign diff    = partial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(DIVIDEND_W);
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff - CNT_W'(1);
         busy_ff <= (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         // the remainder stays below the divisor, so the top bit drops out
         rem_ff <= fits ? diff[DIVISOR_W-1:0] : partial[DIVISOR_W-1:0];
         quo_ff <= {quo_ff[DIVIDEND_W-2:0], fits};
      end
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== hw/rtl/lrs_datapath.sv =====
// Scheduler datapath: config registers, item latch, rate/plateau state, shared
// 32x32 multiplier, divider and cosine table. Depends on lrs_pkg and lrs_divider.
module lrs_datapath #(
   parameter int COS_TABLE_ENTRIES = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [lrs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lrs_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                               req_action,
   input  logic [lrs_pkg::EPOCH_W-1:0]        req_epoch_index,
   input  logic [lrs_pkg::LOSS_W-1:0]         req_validation_loss,
   input  logic                               req_loss_valid,
   input  lrs_pkg::cmd_type                   cmd,
   output lrs_pkg::status_type                status,
   output logic [lrs_pkg::RATE_W-1:0]         rsp_rate,
   output logic                               rsp_rate_reduced
);

   localparam int IDX_W = $clog2(COS_TABLE_ENTRIES + 1);
   localparam int DIV_W = lrs_pkg::EPOCH_W + IDX_W;
   localparam int DVS_W = lrs_pkg::EPOCH_W + 1;

   // cosine table, built at elaboration
   logic [lrs_pkg::H_W-1:0] cos_rom [COS_TABLE_ENTRIES+1];

   for (genvar k = 0; k <= COS_TABLE_ENTRIES; k++) begin : g_rom
      localparam logic [63:0] THETA = (lrs_pkg::PI_Q30 * k) / (2 * COS_TABLE_ENTRIES);
      assign cos_rom[k] = lrs_pkg::cos_sq_q30(THETA);
   end

   // configuration
   logic [1:0]                   mode_ff;
   logic [lrs_pkg::RATE_W-1:0]   base_ff;
   logic [lrs_pkg::GAMMA_W-1:0]  decay_ff;
   logic [lrs_pkg::EPOCH_W-1:0]  step_ff;
   logic [lrs_pkg::EPOCH_W-1:0]  patience_ff;
   logic [lrs_pkg::EPOCH_W-1:0]  total_ff;

   // item latch
   logic                         action_ff;
   logic [lrs_pkg::EPOCH_W-1:0]  epoch_ff;
   logic [lrs_pkg::LOSS_W-1:0]   loss_ff;
   logic                         loss_valid_ff;

   // scheduler state
   logic [lrs_pkg::RATE_W-1:0]   cur_rate_ff;
   logic [lrs_pkg::LOSS_W-1:0]   best_ff;
   logic                         known_ff;
   logic [lrs_pkg::EPOCH_W-1:0]  stall_ff;
   logic                         reduced_ff;

   // work registers
   logic [lrs_pkg::RATE_W-1:0]   r_ff;
   logic [lrs_pkg::RATE_W-1:0]   g_ff;
   logic                         huge_ff;
   logic [lrs_pkg::EPOCH_W-1:0]  pow_bits_ff;
   logic [lrs_pkg::EPOCH_W-1:0]  p_ff;
   logic [lrs_pkg::H_W-1:0]      rom_data_ff;
   logic [63:0]                  prod_ff;
   logic [lrs_pkg::RATE_W-1:0]   out_rate_ff;
   logic                         out_reduced_ff;

   logic [lrs_pkg::EPOCH_W-1:0]  step_eff;
   logic [lrs_pkg::EPOCH_W-1:0]  total_eff;
   logic [DVS_W-1:0]             two_t;
   logic [DIV_W-1:0]             div_dividend;
   logic [DVS_W-1:0]             div_divisor;
   logic                         div_busy;
   logic [DIV_W-1:0]             div_quo;
   logic [DVS_W-1:0]             div_rem;
   logic [DVS_W-1:0]             phase_m;
   logic [IDX_W-1:0]             rom_idx;
   logic [lrs_pkg::RATE_W-1:0]   mul_a;
   logic [lrs_pkg::RATE_W-1:0]   mul_b;
   logic [lrs_pkg::RATE_W-1:0]   sat16;
   logic                         over30;
   logic [lrs_pkg::RATE_W-1:0]   sat30;
   logic                         improve;
   logic [lrs_pkg::EPOCH_W-1:0]  stall_inc;
   logic                         decay_now;

   assign step_eff  = (step_ff == '0) ? lrs_pkg::EPOCH_W'(1) : step_ff;
   assign total_eff = (total_ff == '0) ? lrs_pkg::EPOCH_W'(1) : total_ff;
   assign two_t     = {total_eff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= lrs_pkg::MODE_STEP;
         base_ff     <= '0;
         decay_ff    <= lrs_pkg::DECAY_ONE;
         step_ff     <= lrs_pkg::EPOCH_W'(1);
         patience_ff <= '0;
         total_ff    <= lrs_pkg::EPOCH_W'(1);
      end else if (csr_we) begin
         case (csr_index)
            lrs_pkg::CSR_MODE:     mode_ff     <= csr_wdata[1:0];
            lrs_pkg::CSR_BASE:     base_ff     <= csr_wdata[lrs_pkg::RATE_W-1:0];
            lrs_pkg::CSR_DECAY:    decay_ff    <= csr_wdata[lrs_pkg::GAMMA_W-1:0];
            lrs_pkg::CSR_STEP:     step_ff     <= csr_wdata[lrs_pkg::EPOCH_W-1:0];
            lrs_pkg::CSR_PATIENCE: patience_ff <= csr_wdata[lrs_pkg::EPOCH_W-1:0];
            lrs_pkg::CSR_TOTAL:    total_ff    <= csr_wdata[lrs_pkg::EPOCH_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         action_ff     <= req_action;
         epoch_ff      <= req_epoch_index;
         loss_ff       <= req_validation_loss;
         loss_valid_ff <= req_loss_valid;
      end
   end

   // shared divider: step modulo, cosine phase and table index
   always_comb begin
      case (cmd.div_sel)
         lrs_pkg::DIV_STEP: begin
            div_dividend = DIV_W'({1'b0, epoch_ff} + 17'd1);
            div_divisor  = DVS_W'(step_eff);
         end
         lrs_pkg::DIV_PHASE: begin
            div_dividend = DIV_W'(epoch_ff);
            div_divisor  = two_t;
         end
         lrs_pkg::DIV_INDEX: begin
            div_dividend = DIV_W'(p_ff) * DIV_W'(COS_TABLE_ENTRIES)
                           + DIV_W'(total_eff[lrs_pkg::EPOCH_W-1:1]);
            div_divisor  = DVS_W'(total_eff);
         end
         default: begin
            div_dividend = '0;
            div_divisor  = DVS_W'(1);
         end
      endcase
   end

   lrs_divider #(
      .DIVIDEND_W (DIV_W),
      .DIVISOR_W  (DVS_W)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // mirror the second half of the period
   assign phase_m = (div_rem > {1'b0, total_eff}) ? two_t - div_rem : div_rem;
   assign rom_idx = (div_quo > DIV_W'(COS_TABLE_ENTRIES)) ? IDX_W'(COS_TABLE_ENTRIES)
                                                          : div_quo[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.phase_wb) begin
         p_ff <= phase_m[lrs_pkg::EPOCH_W-1:0];
      end
      if (cmd.rom_rd) begin
         rom_data_ff <= cos_rom[rom_idx];
      end
   end

   // shared multiplier
   always_comb begin
      case (cmd.mul_sel)
         lrs_pkg::MUL_SCALE: begin
            mul_a = cur_rate_ff;
            mul_b = lrs_pkg::RATE_W'(decay_ff);
         end
         lrs_pkg::MUL_COS: begin
            mul_a = base_ff;
            mul_b = lrs_pkg::RATE_W'(rom_data_ff);
         end
         lrs_pkg::MUL_RG: begin
            mul_a = r_ff;
            mul_b = g_ff;
         end
         lrs_pkg::MUL_GG: begin
            mul_a = g_ff;
            mul_b = g_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
   end

   assign sat16  = (|prod_ff[63:48]) ? lrs_pkg::RATE_MAX : prod_ff[47:16];
   assign over30 = |prod_ff[63:62];
   assign sat30  = over30 ? lrs_pkg::RATE_MAX : prod_ff[61:30];

   // plateau tracking
   assign improve   = !known_ff || (loss_ff < best_ff);
   assign stall_inc = (stall_ff == '1) ? stall_ff : stall_ff + lrs_pkg::EPOCH_W'(1);
   assign decay_now = loss_valid_ff && !improve && (stall_inc >= patience_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_rate_ff <= '0;
         best_ff     <= '0;
         known_ff    <= 1'b0;
         stall_ff    <= '0;
         reduced_ff  <= 1'b0;
         huge_ff     <= 1'b0;
      end else begin
         if (cmd.capture) begin
            reduced_ff <= 1'b0;
         end
         if (cmd.start_load) begin
            cur_rate_ff <= base_ff;
            best_ff     <= '0;
            known_ff    <= 1'b0;
            stall_ff    <= '0;
         end
         if (cmd.plat_eval && loss_valid_ff) begin
            if (improve) begin
               best_ff  <= loss_ff;
               known_ff <= 1'b1;
               stall_ff <= '0;
            end else begin
               stall_ff <= decay_now ? '0 : stall_inc;
            end
            reduced_ff <= decay_now;
         end
         if (cmd.pow_init) begin
            huge_ff <= 1'b0;
         end
         case (cmd.wb_sel)
            lrs_pkg::WB_CUR_SCALE: cur_rate_ff <= sat16;
            lrs_pkg::WB_CUR_COS:   cur_rate_ff <= prod_ff[61:30];
            lrs_pkg::WB_CUR_R:     cur_rate_ff <= r_ff;
            lrs_pkg::WB_G: begin
               if (!huge_ff && over30) begin
                  huge_ff <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // power accumulator and squared factor
   always_ff @(posedge clock) begin
      if (cmd.pow_init) begin
         r_ff        <= base_ff;
         g_ff        <= {1'b0, decay_ff, 14'd0};
         pow_bits_ff <= epoch_ff;
      end else begin
         if (cmd.pow_shift) begin
            pow_bits_ff <= pow_bits_ff >> 1;
         end
         if (cmd.wb_sel == lrs_pkg::WB_R) begin
            if (huge_ff) begin
               r_ff <= (r_ff != '0) ? lrs_pkg::RATE_MAX : '0;
            end else begin
               r_ff <= sat30;
            end
         end
         // hold g once it has grown out of range
         if (cmd.wb_sel == lrs_pkg::WB_G && !huge_ff && !over30) begin
            g_ff <= prod_ff[61:30];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_rate_ff    <= cur_rate_ff;
         out_reduced_ff <= reduced_ff;
      end
   end

   assign rsp_rate          = out_rate_ff;
   assign rsp_rate_reduced  = out_reduced_ff;

   assign status.action     = action_ff;
   assign status.mode       = mode_ff;
   assign status.div_busy   = div_busy;
   assign status.rem_zero   = (div_rem == '0);
   assign status.pow_bit    = pow_bits_ff[0];
   assign status.plat_decay = decay_now;

endmodule

// ===== hw/rtl/lrs_ctrl.sv =====
// Scheduler controller: sequences one item at a time through the datapath and
// owns the request and result handshakes. Depends on lrs_pkg.
module lrs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  lrs_pkg::status_type  status,
   output lrs_pkg::cmd_type     cmd
);

   localparam int BIT_W = $clog2(lrs_pkg::EPOCH_W);

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_STEP_WAIT,
      ST_SCALE_MUL,
      ST_SCALE_WB,
      ST_PHASE_WAIT,
      ST_INDEX_START,
      ST_INDEX_WAIT,
      ST_COS_MUL,
      ST_COS_WB,
      ST_POW_MUL_R,
      ST_POW_WB_R,
      ST_POW_MUL_G,
      ST_POW_WB_G,
      ST_POW_FINISH,
      ST_DONE
   } state_type;

   state_type        state_ff;
   state_type        state_in;
   logic [BIT_W-1:0] bit_cnt_ff;
   logic [BIT_W-1:0] bit_cnt_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.div_sel  = lrs_pkg::DIV_STEP;
      cmd.mul_sel  = lrs_pkg::MUL_SCALE;
      cmd.wb_sel   = lrs_pkg::WB_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.action == lrs_pkg::ACT_START) begin
               cmd.start_load = 1'b1;
               state_in       = ST_DONE;
            end else begin
               case (status.mode)
                  lrs_pkg::MODE_STEP: begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = lrs_pkg::DIV_STEP;
                     state_in      = ST_STEP_WAIT;
                  end
                  lrs_pkg::MODE_COSINE: begin
                     cmd.div_start = 1'b1;
                     cmd.div_sel   = lrs_pkg::DIV_PHASE;
                     state_in      = ST_PHASE_WAIT;
                  end
                  lrs_pkg::MODE_PLATEAU: begin
                     cmd.plat_eval = 1'b1;
                     state_in      = status.plat_decay ? ST_SCALE_MUL : ST_DONE;
                  end
                  default: begin
                     cmd.pow_init = 1'b1;
                     bit_cnt_in   = '0;
                     state_in     = ST_POW_MUL_R;
                  end
               endcase
            end
         end
         ST_STEP_WAIT: begin
            cmd.div_sel = lrs_pkg::DIV_STEP;
            if (!status.div_busy) begin
               state_in = status.rem_zero ? ST_SCALE_MUL : ST_DONE;
            end
         end
         ST_SCALE_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lrs_pkg::MUL_SCALE;
            state_in    = ST_SCALE_WB;
         end
         ST_SCALE_WB: begin
            cmd.wb_sel = lrs_pkg::WB_CUR_SCALE;
            state_in   = ST_DONE;
         end
         ST_PHASE_WAIT: begin
            cmd.div_sel = lrs_pkg::DIV_PHASE;
            if (!status.div_busy) begin
               cmd.phase_wb = 1'b1;
               state_in     = ST_INDEX_START;
            end
         end
         ST_INDEX_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = lrs_pkg::DIV_INDEX;
            state_in      = ST_INDEX_WAIT;
         end
         ST_INDEX_WAIT: begin
            cmd.div_sel = lrs_pkg::DIV_INDEX;
            if (!status.div_busy) begin
               cmd.rom_rd = 1'b1;
               state_in   = ST_COS_MUL;
            end
         end
         ST_COS_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lrs_pkg::MUL_COS;
            state_in    = ST_COS_WB;
         end
         ST_COS_WB: begin
            cmd.wb_sel = lrs_pkg::WB_CUR_COS;
            state_in   = ST_DONE;
         end
         ST_POW_MUL_R: begin
            // skip the rate update on a clear epoch bit
            if (status.pow_bit) begin
               cmd.mul_en  = 1'b1;
               cmd.mul_sel = lrs_pkg::MUL_RG;
               state_in    = ST_POW_WB_R;
            end else begin
               state_in = ST_POW_MUL_G;
            end
         end
         ST_POW_WB_R: begin
            cmd.wb_sel = lrs_pkg::WB_R;
            state_in   = ST_POW_MUL_G;
         end
         ST_POW_MUL_G: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = lrs_pkg::MUL_GG;
            state_in    = ST_POW_WB_G;
         end
         ST_POW_WB_G: begin
            cmd.wb_sel    = lrs_pkg::WB_G;
            cmd.pow_shift = 1'b1;
            if (bit_cnt_ff == BIT_W'(lrs_pkg::EPOCH_W - 1)) begin
               state_in = ST_POW_FINISH;
            end else begin
               bit_cnt_in = bit_cnt_ff + BIT_W'(1);
               state_in   = ST_POW_MUL_R;
            end
         end
         ST_POW_FINISH: begin
            cmd.wb_sel = lrs_pkg::WB_CUR_R;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            // hand the item over once the result register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/learning_rate_scheduler_top.sv =====
// Start events and plateau epochs without a decay go straight to the result; a plateau decay
// adds a multiply and write-back; step mode runs one restoring-divider pass, plus the decay
// on a hit; cosine runs two divider passes (phase, then table index), a table read and a multiply;
// exponential walks all 16 epoch bits, squaring the factor each bit and multiplying on a set bit.
// One item at a time; the next is taken in the cycle after the result is registered.
// Synchronous reset clears config to its defaults, the rate and plateau state, no result.
module learning_rate_scheduler_top #(
   parameter int COS_TABLE_ENTRIES = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_action,
   input  logic [lrs_pkg::EPOCH_W-1:0]     req_epoch_index,
   input  logic [lrs_pkg::LOSS_W-1:0]      req_validation_loss,
   input  logic                            req_loss_valid,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [lrs_pkg::RATE_W-1:0]      rsp_rate,
   output logic                            rsp_rate_reduced,
   input  logic                            csr_we,
   input  logic [lrs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [lrs_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   lrs_pkg::cmd_type    cmd;
   lrs_pkg::status_type status;

   lrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lrs_datapath #(
      .COS_TABLE_ENTRIES (COS_TABLE_ENTRIES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_action          (req_action),
      .req_epoch_index     (req_epoch_index),
      .req_validation_loss (req_validation_loss),
      .req_loss_valid      (req_loss_valid),
      .cmd                 (cmd),
      .status              (status),
      .rsp_rate            (rsp_rate),
      .rsp_rate_reduced    (rsp_rate_reduced)
   );

endmodule

// ===== tb/learning_rate_scheduler_top_tb.sv =====
// Self-checking testbench for learning_rate_scheduler_top: directed and random scheduler items,
// each result checked against an in-bench predictor of the four schedule modes.
// Depends on lrs_pkg and the learning_rate_scheduler_top RTL.
module learning_rate_scheduler_top_tb;

   localparam int COS_ENTRIES  = 256;
   localparam int RANDOM_ITEMS = 1650;
   localparam int QUIET_LIMIT  = 4000;
   localparam logic [63:0] ROM_LAST = 64'(COS_ENTRIES);
   localparam logic [63:0] SAT_LIMIT = {32'd0, lrs_pkg::RATE_MAX};
   localparam logic [lrs_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [lrs_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                         action;
      logic [lrs_pkg::EPOCH_W-1:0]  epoch;
      logic [lrs_pkg::LOSS_W-1:0]   loss;
      logic                         loss_ok;
   } sched_item_type;

   typedef struct packed {
      logic [lrs_pkg::RATE_W-1:0] rate;
      logic                       reduced;
   } rate_update_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic                            req_action = lrs_pkg::ACT_START;
   logic [lrs_pkg::EPOCH_W-1:0]     req_epoch_index = '0;
   logic [lrs_pkg::LOSS_W-1:0]      req_validation_loss = '0;
   logic                            req_loss_valid = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic [lrs_pkg::RATE_W-1:0]      rsp_rate;
   logic                            rsp_rate_reduced;
   logic                            csr_we = 1'b0;
   logic [lrs_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [lrs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // predictor copy of the registers and the scheduler state
   logic [1:0]                   cfg_mode = lrs_pkg::MODE_STEP;
   logic [lrs_pkg::RATE_W-1:0]   cfg_base = '0;
   logic [lrs_pkg::GAMMA_W-1:0]  cfg_decay = lrs_pkg::DECAY_ONE;
   logic [15:0]                  cfg_step = 16'd1;
   logic [15:0]                  cfg_patience = 16'd0;
   logic [15:0]                  cfg_total = 16'd1;
   logic [lrs_pkg::RATE_W-1:0]   rate_now = '0;
   logic [lrs_pkg::LOSS_W-1:0]   best_loss = '0;
   logic                         best_known = 1'b0;
   logic [15:0]                  plateau_stalls = '0;
   logic [30:0]                  cos_sq_rom [0:COS_ENTRIES];

   sched_item_type  pending_items[$];
   rate_update_type expected_rates[$];

   int unsigned items_issued = 0;
   int unsigned results_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned req_gap_left = 0;
   int unsigned rsp_stall_left = 0;
   int unsigned quiet_cycles = 0;
   int unsigned cfg_settings = 0;
   int unsigned csr_writes = 0;
   int unsigned start_count = 0;
   int unsigned decays_seen = 0;
   int unsigned mode_hits [4] = '{0, 0, 0, 0};
   bit          idle_on = 1'b1;

   learning_rate_scheduler_top #(
      .COS_TABLE_ENTRIES(COS_ENTRIES)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_epoch_index    (req_epoch_index),
      .req_validation_loss(req_validation_loss),
      .req_loss_valid     (req_loss_valid),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_rate           (rsp_rate),
      .rsp_rate_reduced   (rsp_rate_reduced),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // cos^2 half-period table in Q1.30, Horner-form Taylor series
   initial begin : build_cos_rom
      logic [63:0] k, ang, sq, term, part, den, c2;
      int i;
      for (k = 0; k <= ROM_LAST; k++) begin
         ang  = (lrs_pkg::PI_Q30 * k) / (2 * ROM_LAST);
         sq   = (ang * ang) >> 30;
         term = lrs_pkg::Q30_ONE;
         for (i = 0; i < 7; i++) begin
            case (i)
               0: den = 64'd182;
               1: den = 64'd132;
               2: den = 64'd90;
               3: den = 64'd56;
               4: den = 64'd30;
               5: den = 64'd12;
               default: den = 64'd2;
            endcase
            part = ((sq * term) >> 30) / den;
            term = (part >= lrs_pkg::Q30_ONE) ? 64'd0 : lrs_pkg::Q30_ONE - part;
         end
         c2 = (term * term) >> 30;
         if (c2 > lrs_pkg::Q30_ONE) begin
            c2 = lrs_pkg::Q30_ONE;
         end
         cos_sq_rom[k] = c2[30:0];
      end
   end

   function automatic logic [lrs_pkg::RATE_W-1:0] scale_rate(
         input logic [lrs_pkg::RATE_W-1:0] rate, input logic [lrs_pkg::GAMMA_W-1:0] gamma);
      logic [63:0] prod;
      prod = ({32'd0, rate} * {47'd0, gamma}) >> 16;
      return (prod > SAT_LIMIT) ? lrs_pkg::RATE_MAX : prod[31:0];
   endfunction

   function automatic logic [lrs_pkg::RATE_W-1:0] cosine_rate(
         input logic [lrs_pkg::EPOCH_W-1:0] epoch);
      logic [63:0] span, phase, idx, prod;
      span  = (cfg_total == 16'd0) ? 64'd1 : {48'd0, cfg_total};
      phase = {48'd0, epoch} % (2 * span);
      // mirror the second half of the period
      if (phase > span) begin
         phase = 2 * span - phase;
      end
      idx = (phase * ROM_LAST + span / 2) / span;
      if (idx > ROM_LAST) begin
         idx = ROM_LAST;
      end
      prod = ({32'd0, cfg_base} * {33'd0, cos_sq_rom[idx]}) >> 30;
      return prod[31:0];
   endfunction

   function automatic logic [lrs_pkg::RATE_W-1:0] power_rate(
         input logic [lrs_pkg::EPOCH_W-1:0] epoch);
      logic [63:0] r, g;
      logic        huge;
      int          b;
      r    = {32'd0, cfg_base};
      g    = {47'd0, cfg_decay} << 14;
      huge = 1'b0;
      for (b = 0; b < lrs_pkg::EPOCH_W; b++) begin
         if (epoch[b]) begin
            if (huge) begin
               r = (r != 64'd0) ? SAT_LIMIT : 64'd0;
            end else begin
               r = (r * g) >> 30;
               if (r > SAT_LIMIT) begin
                  r = SAT_LIMIT;
               end
            end
         end
         // hold an oversized factor as saturated from here on
         if (!huge) begin
            g = (g * g) >> 30;
            if (g > SAT_LIMIT) begin
               huge = 1'b1;
            end
         end
      end
      return r[31:0];
   endfunction

   function automatic rate_update_type advance_schedule(input sched_item_type it);
      rate_update_type upd;
      logic [31:0]     interval;
      upd.reduced = 1'b0;
      if (it.action == lrs_pkg::ACT_START) begin
         rate_now       = cfg_base;
         best_loss      = '0;
         best_known     = 1'b0;
         plateau_stalls = '0;
         start_count++;
      end else begin
         mode_hits[cfg_mode]++;
         case (cfg_mode)
            lrs_pkg::MODE_STEP: begin
               interval = (cfg_step == 16'd0) ? 32'd1 : {16'd0, cfg_step};
               if ((({16'd0, it.epoch}) + 32'd1) % interval == 32'd0) begin
                  rate_now = scale_rate(rate_now, cfg_decay);
               end
            end
            lrs_pkg::MODE_COSINE: begin
               rate_now = cosine_rate(it.epoch);
            end
            lrs_pkg::MODE_PLATEAU: begin
               if (it.loss_ok) begin
                  if (!best_known || it.loss < best_loss) begin
                     best_loss      = it.loss;
                     best_known     = 1'b1;
                     plateau_stalls = '0;
                  end else begin
                     if (plateau_stalls != 16'hFFFF) begin
                        plateau_stalls++;
                     end
                     if (plateau_stalls >= cfg_patience) begin
                        rate_now       = scale_rate(rate_now, cfg_decay);
                        plateau_stalls = '0;
                        upd.reduced    = 1'b1;
                        decays_seen++;
                     end
                  end
               end
            end
            default: begin
               rate_now = power_rate(it.epoch);
            end
         endcase
      end
      upd.rate = rate_now;
      return upd;
   endfunction

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         return $urandom_range(1, 3);
      end
      if (r < 95) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [31:0] with_junk(input logic [31:0] value, input int width);
      logic [31:0] keep;
      keep = (width >= 32) ? 32'hFFFF_FFFF : ((32'd1 << width) - 32'd1);
      if ($urandom_range(0, 3) == 0) begin
         return (value & keep) | ($urandom() & ~keep);
      end
      return value & keep;
   endfunction

   task automatic write_csr(input logic [lrs_pkg::CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         lrs_pkg::CSR_MODE:     cfg_mode     = data[1:0];
         lrs_pkg::CSR_BASE:     cfg_base     = data;
         lrs_pkg::CSR_DECAY:    cfg_decay    = data[lrs_pkg::GAMMA_W-1:0];
         lrs_pkg::CSR_STEP:     cfg_step     = data[15:0];
         lrs_pkg::CSR_PATIENCE: cfg_patience = data[15:0];
         lrs_pkg::CSR_TOTAL:    cfg_total    = data[15:0];
         default: ;
      endcase
      csr_writes++;
   endtask

   task automatic queue_start();
      sched_item_type it;
      it.action  = lrs_pkg::ACT_START;
      it.epoch   = 16'($urandom());
      it.loss    = $urandom();
      it.loss_ok = 1'($urandom_range(0, 1));
      pending_items = {pending_items, it};
      items_issued++;
   endtask

   task automatic queue_epoch(input logic [lrs_pkg::EPOCH_W-1:0] epoch,
                              input logic [lrs_pkg::LOSS_W-1:0] loss, input logic ok);
      sched_item_type it;
      it.action  = lrs_pkg::ACT_EPOCH_END;
      it.epoch   = epoch;
      it.loss    = loss;
      it.loss_ok = ok;
      pending_items = {pending_items, it};
      items_issued++;
   endtask

   // wait until every issued item has its result, then let the block go idle
   task automatic settle();
      while (results_seen != items_issued) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : drive_req
      sched_item_type  nxt;
      rate_update_type upd;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            nxt.action  = req_action;
            nxt.epoch   = req_epoch_index;
            nxt.loss    = req_validation_loss;
            nxt.loss_ok = req_loss_valid;
            upd = advance_schedule(nxt);
            expected_rates = {expected_rates, upd};
         end
         // hold a stalled item, otherwise advance to the next one
         if (!req_valid || !req_stall) begin
            if (req_gap_left != 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               nxt = pending_items.pop_front();
               req_action          <= nxt.action;
               req_epoch_index     <= nxt.epoch;
               req_validation_loss <= nxt.loss;
               req_loss_valid      <= nxt.loss_ok;
               req_valid           <= 1'b1;
               req_gap_left = (idle_on && $urandom_range(0, 1) == 1) ? idle_length() : 0;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rate_update_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_rates.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected item, expected none, actual rate %h reduced %b",
                        $time, rsp_rate, rsp_rate_reduced);
            end else begin
               want = expected_rates.pop_front();
               if (rsp_rate !== want.rate) begin
                  mismatch_count++;
                  $display("%0t: rate mismatch, expected %h, actual %h", $time,
                           want.rate, rsp_rate);
               end
               if (rsp_rate_reduced !== want.reduced) begin
                  mismatch_count++;
                  $display("%0t: rate_reduced mismatch, expected %b, actual %b", $time,
                           want.reduced, rsp_rate_reduced);
               end
            end
         end
         if (rsp_stall_left != 0) begin
            rsp_stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_stall_left = idle_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [31:0]                 pick;
      logic [31:0]                 drop;
      logic [lrs_pkg::EPOCH_W-1:0] epoch;
      logic [lrs_pkg::LOSS_W-1:0]  loss;
      int unsigned                 run_len;
      int unsigned                 n;
      int unsigned                 random_items;
      random_items = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // register defaults straight after reset
      queue_start();
      queue_epoch(16'd0, 32'd0, 1'b0);
      settle();

      // step mode: masked writes, zero interval, saturating decay, unused indexes
      write_csr(lrs_pkg::CSR_MODE, 32'hFFFF_FFFC);
      write_csr(lrs_pkg::CSR_BASE, lrs_pkg::RATE_MAX);
      write_csr(lrs_pkg::CSR_DECAY, 32'hFFFF_FFFF);
      write_csr(lrs_pkg::CSR_STEP, 32'hABCD_0000);
      write_csr(lrs_pkg::CSR_PATIENCE, 32'd0);
      write_csr(lrs_pkg::CSR_TOTAL, 32'h0001_0000);
      write_csr(CSR_SPARE_LO, $urandom());
      write_csr(CSR_SPARE_HI, $urandom());
      @(posedge clock) csr_we <= 1'b0;
      cfg_settings++;
      queue_start();
      queue_epoch(16'hFFFF, 32'hFFFF_FFFF, 1'b1);
      queue_epoch(16'd0, 32'd0, 1'b0);
      settle();

      // step mode at the largest interval
      write_csr(lrs_pkg::CSR_BASE, 32'h8000_0000);
      write_csr(lrs_pkg::CSR_DECAY, 32'd32768);
      write_csr(lrs_pkg::CSR_STEP, 32'd65535);
      @(posedge clock) csr_we <= 1'b0;
      cfg_settings++;
      queue_start();
      queue_epoch(16'd65534, 32'd0, 1'b1);
      queue_epoch(16'd0, 32'd0, 1'b1);
      queue_epoch(16'hFFFF, 32'd0, 1'b1);
      settle();

      // cosine: zero period and wrap-around, then the longest period
      write_csr(lrs_pkg::CSR_MODE, 32'(lrs_pkg::MODE_COSINE));
      write_csr(lrs_pkg::CSR_BASE, lrs_pkg::RATE_MAX);
      @(posedge clock) csr_we <= 1'b0;
      cfg_settings++;
      queue_epoch(16'd0, 32'd0, 1'b1);
      queue_epoch(16'd1, 32'd0, 1'b1);
      queue_epoch(16'd2, 32'd0, 1'b1);
      settle();
      write_csr(lrs_pkg::CSR_TOTAL, 32'd65535);
      @(posedge clock) csr_we <= 1'b0;
      cfg_settings++;
      queue_epoch(16'd0, 32'd0, 1'b1);
      queue_epoch(16'd32767, 32'd0, 1'b1);
      queue_epoch(16'hFFFF, 32'd0, 1'b1);
      settle();

      // plateau with zero patience and an invalid loss in between
      write_csr(lrs_pkg::CSR_MODE, 32'(lrs_pkg::MODE_PLATEAU));
      write_csr(lrs_pkg::CSR_BASE, 32'h4000_0000);
      write_csr(lrs_pkg::CSR_DECAY, 32'd32768);
      write_csr(lrs_pkg::CSR_PATIENCE, 32'd0);
      @(posedge clock) csr_we <= 1'b0;
      cfg_settings++;
      queue_start();
      queue_epoch(16'd0, 32'd100, 1'b1);
      queue_epoch(16'd1, 32'd100, 1'b1);
      queue_epoch(16'd2, 32'hFFFF_FFFF, 1'b0);
      queue_epoch(16'd3, 32'd0, 1'b1);
      queue_epoch(16'd4, 32'hFFFF_FFFF, 1'b1);
      settle();

      // exponential: oversized factor, zero base, zero factor, unit factor
      write_csr(lrs_pkg::CSR_MODE, 32'(lrs_pkg::MODE_EXP));
      write_csr(lrs_pkg::CSR_DECAY, 32'd131071);
      write_csr(lrs_pkg::CSR_BASE, 32'd1);
      @(posedge clock) csr_we <= 1'b0;
      cfg_settings++;
      queue_epoch(16'hFFFF, 32'd0, 1'b1);
      settle();
      write_csr(lrs_pkg::CSR_BASE, 32'd0);
      @(posedge clock) csr_we <= 1'b0;
      queue_epoch(16'hFFFF, 32'd0, 1'b1);
      settle();
      write_csr(lrs_pkg::CSR_DECAY, 32'd0);
      write_csr(lrs_pkg::CSR_BASE, lrs_pkg::RATE_MAX);
      @(posedge clock) csr_we <= 1'b0;
      queue_epoch(16'd1, 32'd0, 1'b1);
      settle();
      write_csr(lrs_pkg::CSR_DECAY, 32'(lrs_pkg::DECAY_ONE));
      @(posedge clock) csr_we <= 1'b0;
      queue_epoch(16'hFFFF, 32'd0, 1'b1);
      settle();

      // random training runs, each under a fresh register setting
      while (random_items < RANDOM_ITEMS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         write_csr(lrs_pkg::CSR_MODE, with_junk($urandom_range(0, 3), 2));
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: pick = 32'd0;
               1: pick = lrs_pkg::RATE_MAX;
               default: pick = $urandom();
            endcase
            write_csr(lrs_pkg::CSR_BASE, pick);
         end
         if ($urandom_range(0, 3) != 0) begin
            case ($urandom_range(0, 9))
               0: pick = 32'd0;
               1: pick = 32'(lrs_pkg::DECAY_ONE);
               2: pick = 32'd131071;
               3: pick = $urandom_range(0, 131071);
               default: pick = $urandom_range(50000, 65536);
            endcase
            write_csr(lrs_pkg::CSR_DECAY, with_junk(pick, lrs_pkg::GAMMA_W));
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0: pick = 32'd0;
               1: pick = 32'd65535;
               2: pick = $urandom_range(0, 65535);
               default: pick = $urandom_range(1, 8);
            endcase
            write_csr(lrs_pkg::CSR_STEP, with_junk(pick, 16));
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0: pick = 32'd65535;
               1: pick = $urandom_range(0, 65535);
               default: pick = $urandom_range(0, 4);
            endcase
            write_csr(lrs_pkg::CSR_PATIENCE, with_junk(pick, 16));
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 9))
               0: pick = 32'd0;
               1: pick = 32'd65535;
               2: pick = $urandom_range(0, 65535);
               default: pick = $urandom_range(1, 60);
            endcase
            write_csr(lrs_pkg::CSR_TOTAL, with_junk(pick, 16));
         end
         @(posedge clock) csr_we <= 1'b0;
         cfg_settings++;

         run_len = $urandom_range(15, 70);
         if ($urandom_range(0, 9) != 0) begin
            queue_start();
         end
         epoch = ($urandom_range(0, 3) == 0) ? 16'($urandom()) : 16'd0;
         loss  = $urandom();
         for (n = 0; n < run_len; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               queue_start();
               epoch = 16'd0;
            end else begin
               if (pick < 22) begin
                  epoch = 16'($urandom());
               end
               drop = $urandom_range(0, 4095) << $urandom_range(0, 16);
               case ($urandom_range(0, 9))
                  0, 1, 2: loss = (loss > drop) ? loss - drop : 32'd0;
                  3, 4:    loss = loss;
                  5, 6, 7: loss = loss + drop;
                  8:       loss = $urandom();
                  default: loss = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
               endcase
               queue_epoch(epoch, loss, $urandom_range(0, 9) != 0);
               epoch++;
            end
         end
         random_items += run_len;
         settle();
      end

      repeat (100) @(posedge clock);
      $display("Summary: %0d scheduler items, %0d register settings (%0d writes), %0d starts",
               items_issued, cfg_settings, csr_writes, start_count);
      $display("Epoch ends: step %0d, cosine %0d, plateau %0d (%0d decays), exponential %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], decays_seen, mode_hits[3]);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
